>>> rtl/core/spq_pkg.sv
package spq_pkg;

  // Field widths of the stream words
  localparam int unsigned OP_W   = 2;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned PRI_W  = 8;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned OCC_W  = 5;

  // Packed word widths (tdata rounded up to whole bytes)
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
  localparam logic [OP_W-1:0] OP_POP     = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_INVALID  = 3'd4;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [PRI_W-1:0] pri_t;

  // One request as held in the input register
  typedef struct packed {
    logic [OP_W-1:0] op;
    id_t             id;
    pri_t            pri;
  } req_t;

endpackage

>>> rtl/core/stable_priority_queue_core.sv
// Stable priority queue: up to DEPTH entries (16-bit id, 8-bit priority)
// kept sorted by priority, 1 most urgent, equal priorities in arrival order.
// Input channel in_*: in_tuser carries the operation (enqueue, pop head,
// remove by id), in_tdata the id and priority. Result channel out_*: one
// word per request, out_tuser carries the status, out_tdata the popped or
// removed entry and the occupancy after the operation.
// A request accepted on in_* passes the input register, then the result
// register, and is presented on out_*. Throughput: one word per cycle while
// out_tready is high. Every slot compares its priority and id with the request
// in parallel, and the entries past the insert or remove point shift one place
// up or down in the same cycle, so the next request sees the updated queue.
// Reset (rst_n low, synchronous) empties the queue and drops any word in
// flight; slot contents are not cleared, only the entry count.
// When the receiver holds out_tready low, the result word stays on out_*,
// the input register holds its request and in_tready falls once both
// registers are full; nothing is lost or repeated.
module stable_priority_queue_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [spq_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] process_id, [23:16] priority_req
  input  logic [spq_pkg::OP_W-1:0]       in_tuser,   // [1:0] operation
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [spq_pkg::OUT_DATA_W-1:0] out_tdata,  // [15:0] result_id,
                                                     // [23:16] result_priority,
                                                     // [28:24] occupancy
  output logic [spq_pkg::ST_W-1:0]       out_tuser   // [2:0] status
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LV = $clog2(DEPTH);

  // Input register
  logic  req_vld_r;
  req_t  req_r;

  // Result register
  logic                  res_vld_r;
  logic [ST_W-1:0]       res_st_r;
  id_t                   res_id_r;
  pri_t                  res_pri_r;
  logic [OCC_W-1:0]      res_occ_r;

  // Entry array and fill count
  id_t            slot_id_r  [DEPTH];
  pri_t           slot_pri_r [DEPTH];
  id_t            slot_id_nxt  [DEPTH];
  pri_t           slot_pri_nxt [DEPTH];
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;

  logic             res_free;
  logic             req_fire;
  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] after;
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] incl;
  logic [DEPTH-1:0] first;
  logic [DEPTH-1:0] del_mask;
  logic             found;
  logic             is_empty;
  logic             is_full;
  logic             enq_ok;
  logic             del_ok;
  id_t              sel_id;
  pri_t             sel_pri;
  logic [ST_W-1:0]  st;
  id_t              rid;
  pri_t             rpr;

  // Handshake: result register frees when taken, input register moves on then
  assign res_free  = !res_vld_r || out_tready;
  assign req_fire  = req_vld_r && res_free;
  assign in_tready = !req_vld_r || res_free;

  // Per-slot compares
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      vld[i]   = count_r > CW'(i);
      // empty slots count as greater, so after[] is a suffix mask
      after[i] = !vld[i] || (slot_pri_r[i] > req_r.pri);
      match[i] = vld[i] && (slot_id_r[i] == req_r.id);
    end
  end

  // First id match: log-depth prefix OR, then isolate the lowest hit
  always_comb begin
    incl = match;
    for (int l = 0; l < LV; l++) begin
      incl = incl | (incl << (1 << l));
    end
    first = match & ~(incl << 1);
    found = |match;
  end

  // Matched entry, one-hot select
  always_comb begin
    sel_id  = '0;
    sel_pri = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_id  = sel_id  | (first[i] ? slot_id_r[i]  : '0);
      sel_pri = sel_pri | (first[i] ? slot_pri_r[i] : '0);
    end
  end

  // Operation decode and status
  always_comb begin
    is_empty = (count_r == '0);
    is_full  = (count_r == CW'(DEPTH));
    enq_ok   = 1'b0;
    del_ok   = 1'b0;
    del_mask = incl;
    rid      = '0;
    rpr      = '0;
    st       = ST_OK;
    unique case (req_r.op)
      OP_ENQUEUE: begin
        if (req_r.id == '0 || req_r.pri == '0) begin
          st = ST_INVALID;
        end else if (is_full) begin
          st = ST_FULL;
        end else begin
          enq_ok = 1'b1;
        end
      end
      OP_POP: begin
        del_mask = '1;
        if (is_empty) begin
          st = ST_EMPTY;
        end else begin
          del_ok = 1'b1;
          rid    = slot_id_r[0];
          rpr    = slot_pri_r[0];
        end
      end
      OP_REMOVE: begin
        if (found) begin
          del_ok = 1'b1;
          rid    = sel_id;
          rpr    = sel_pri;
        end else begin
          st = ST_NOTFOUND;
        end
      end
      default: begin
        st = ST_INVALID;
      end
    endcase
  end

  // Array shift: insert moves the tail up one, delete closes the gap
  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < DEPTH; i++) begin
      slot_id_nxt[i]  = slot_id_r[i];
      slot_pri_nxt[i] = slot_pri_r[i];
    end
    if (enq_ok) begin
      count_nxt = count_r + 1'b1;
      for (int i = 0; i < DEPTH; i++) begin
        if (i > 0 && after[(i > 0) ? i - 1 : 0]) begin
          slot_id_nxt[i]  = slot_id_r[(i > 0) ? i - 1 : 0];
          slot_pri_nxt[i] = slot_pri_r[(i > 0) ? i - 1 : 0];
        end else if (after[i]) begin
          slot_id_nxt[i]  = req_r.id;
          slot_pri_nxt[i] = req_r.pri;
        end
      end
    end else if (del_ok) begin
      count_nxt = count_r - 1'b1;
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (del_mask[i]) begin
          slot_id_nxt[i]  = slot_id_r[i + 1];
          slot_pri_nxt[i] = slot_pri_r[i + 1];
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
      count_r   <= '0;
    end else begin
      if (in_tready) begin
        req_vld_r <= in_tvalid;
      end
      if (res_free) begin
        res_vld_r <= req_vld_r;
      end
      if (req_fire) begin
        count_r <= count_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r.op  <= in_tuser;
      req_r.id  <= in_tdata[ID_W-1:0];
      req_r.pri <= in_tdata[ID_W +: PRI_W];
    end
    if (req_fire) begin
      res_st_r  <= st;
      res_id_r  <= rid;
      res_pri_r <= rpr;
      res_occ_r <= OCC_W'(count_nxt);
      for (int i = 0; i < DEPTH; i++) begin
        slot_id_r[i]  <= slot_id_nxt[i];
        slot_pri_r[i] <= slot_pri_nxt[i];
      end
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tuser  = res_st_r;
  assign out_tdata  = {{(OUT_DATA_W - OCC_W - PRI_W - ID_W){1'b0}},
                       res_occ_r, res_pri_r, res_id_r};

`ifndef SYNTHESIS
  // fill count stays within the array
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  // one request moves the count by at most one entry
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + 1'b1) ||
    (count_r == $past(count_r) - 1'b1))
    else $error("entry count jumped");

  // the count only changes when a request leaves the input register
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !req_fire |=> count_r == $past(count_r))
    else $error("entry count changed without a request");

  // failed requests return no entry
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> out_tdata[ID_W+PRI_W-1:0] == '0)
    else $error("entry returned with error status");
`endif

endmodule
